// ===== rtl/evf_pkg.sv =====
`default_nettype none
package evf_pkg;

  // Field widths.
  localparam int CNT_W   = 16;
  localparam int DLT_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int LIM_W   = 15;
  localparam int SCALE_W = 24;
  localparam int BAND_W  = 16;
  localparam int HOLD_W  = 8;
  localparam int FILT_W  = 32;
  localparam int SPEED_W = 21;

  // Digit-serial multiplier geometry.
  localparam int MC_W       = 33;
  localparam int MUL_W      = 24;
  localparam int DIGIT_W    = 4;
  localparam int STEPS      = MUL_W / DIGIT_W;
  localparam int STEP_CNT_W = $clog2(STEPS);
  localparam int HI_W       = MC_W + 1;
  localparam int SUM_W      = HI_W + DIGIT_W;
  localparam int PROD_W     = HI_W + MUL_W;

  // Fixed-point scaling.
  localparam int FILT_SH  = 15;
  localparam int SPEED_SH = 24;
  localparam int RND_W    = PROD_W - FILT_SH;
  localparam int FSUM_W   = RND_W + 1;
  localparam int SPQ_W    = PROD_W - SPEED_SH;

  localparam logic [PROD_W-1:0] RND_FILT  = PROD_W'(1) << (FILT_SH - 1);
  localparam logic [PROD_W-1:0] RND_SPEED = PROD_W'(1) << (SPEED_SH - 1);

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(32768);
  localparam int FILT_MAX  = 2147418112;
  localparam int SPEED_MAX = 1048575;
  localparam int SPEED_MIN = -1048576;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DELTA_LIMIT      = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE      = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_BAND        = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HOLD_FRAMES = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_LEFT      = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_RIGHT     = CFG_IDX_W'(6);

  localparam logic [GAIN_W-1:0]  RST_GAIN  = GAIN_W'(9830);
  localparam logic [LIM_W-1:0]   RST_LIMIT = LIM_W'(300);
  localparam logic [SCALE_W-1:0] RST_SCALE = SCALE_W'(43924);
  localparam logic [BAND_W-1:0]  RST_BAND  = BAND_W'(66);
  localparam logic [HOLD_W-1:0]  RST_HOLD  = HOLD_W'(3);

  typedef struct packed {
    logic [GAIN_W-1:0]  gain;
    logic [LIM_W-1:0]   limit;
    logic [SCALE_W-1:0] scale;
    logic [BAND_W-1:0]  band;
    logic [HOLD_W-1:0]  hold;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic prime;
  } wheel_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/evf_serial_mult.sv =====
`default_nettype none
module evf_serial_mult
  import evf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [MC_W-1:0]   mcand,
  input  logic        [MUL_W-1:0]  mult,
  output logic                     done,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [MC_W-1:0]   mcand_r;
  logic [HI_W-1:0]          hi_r;
  logic [HI_W-1:0]          hi_nxt;
  logic [MUL_W-1:0]         lo_r;
  logic [MUL_W-1:0]         lo_nxt;
  logic [STEP_CNT_W-1:0]    cnt_r;
  logic                     busy_r;
  logic                     done_r;
  logic signed [DIGIT_W:0]  digit;
  logic signed [SUM_W-1:0]  pp;
  logic signed [SUM_W-1:0]  sum;

  // One multiplier digit per cycle, low digit first; the partial sum shifts
  // down into the low half as the multiplier digits shift out.
  assign digit  = $signed({1'b0, lo_r[DIGIT_W-1:0]});
  assign pp     = mcand_r * digit;
  assign sum    = $signed({{DIGIT_W{hi_r[HI_W-1]}}, hi_r}) + pp;
  assign hi_nxt = sum[SUM_W-1:DIGIT_W];
  assign lo_nxt = {sum[DIGIT_W-1:0], lo_r[MUL_W-1:DIGIT_W]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + STEP_CNT_W'(1);
        if (cnt_r == STEP_CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= mcand;
      hi_r    <= '0;
      lo_r    <= mult;
    end else if (busy_r) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign done = done_r;
  assign prod = $signed({hi_r, lo_r});

endmodule
`default_nettype wire

// ===== rtl/evf_wheel.sv =====
`default_nettype none
module evf_wheel
  import evf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  wheel_cmd_t                cmd,
  input  logic [CNT_W-1:0]          count,
  input  logic                      inv,
  input  cfg_t                      cfg,
  output logic                      done,
  output logic signed [SPEED_W-1:0] speed,
  output logic signed [FILT_W-1:0]  filt
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD1 = 3'd1;
  localparam logic [2:0] S_MUL1  = 3'd2;
  localparam logic [2:0] S_FILT  = 3'd3;
  localparam logic [2:0] S_LOAD2 = 3'd4;
  localparam logic [2:0] S_MUL2  = 3'd5;
  localparam logic [2:0] S_HOLD  = 3'd6;

  logic [2:0]                state_r;
  logic [2:0]                state_nxt;
  logic                      done_r;
  logic [CNT_W-1:0]          prev_r;
  logic signed [FILT_W-1:0]  filt_r;
  logic signed [SPEED_W-1:0] vspd_r;
  logic [HOLD_W-1:0]         run_r;
  logic signed [DLT_W-1:0]   d_r;
  logic signed [RND_W-1:0]   rnd_r;
  logic signed [SPEED_W-1:0] spd_c_r;
  logic signed [SPEED_W-1:0] res_spd_r;

  logic [CNT_W-1:0]          raw;
  logic signed [DLT_W:0]     dx;
  logic signed [DLT_W:0]     dn;
  logic signed [DLT_W:0]     lim_s;
  logic signed [DLT_W:0]     neg_lim;
  logic signed [DLT_W-1:0]   d_c;
  logic [GAIN_W-1:0]         g;

  logic                      mul_start;
  logic signed [MC_W-1:0]    mul_mcand;
  logic [MUL_W-1:0]          mul_mult;
  logic                      mul_done;
  logic signed [PROD_W-1:0]  prod;

  logic [PROD_W-1:0]         t1;
  logic [PROD_W-1:0]         t2;
  logic signed [FSUM_W-1:0]  fsum;
  logic signed [FSUM_W-1:0]  f_max_s;
  logic signed [FSUM_W-1:0]  f_min_s;
  logic signed [FILT_W-1:0]  f_c;
  logic signed [SPQ_W-1:0]   q2;
  logic signed [SPQ_W-1:0]   s_max_s;
  logic signed [SPQ_W-1:0]   s_min_s;
  logic signed [SPEED_W-1:0] s_c;
  logic signed [SPEED_W:0]   spd_x;
  logic [SPEED_W:0]          mag;
  logic                      near;
  logic [HOLD_W-1:0]         run_inc;

  // Count difference, modulo the counter width, read as signed.
  assign raw     = count - prev_r;
  assign dx      = $signed({raw[CNT_W-1], raw});
  assign dn      = inv ? -dx : dx;
  assign lim_s   = $signed({2'b00, cfg.limit});
  assign neg_lim = -lim_s;

  always_comb begin
    if (dn > lim_s) begin
      d_c = lim_s[DLT_W-1:0];
    end else if (dn < neg_lim) begin
      d_c = neg_lim[DLT_W-1:0];
    end else begin
      d_c = dn[DLT_W-1:0];
    end
  end

  assign g = (cfg.gain > GAIN_ONE) ? GAIN_ONE : cfg.gain;

  // The filter g*(d<<16) + (1-g)*filt is computed as g*((d<<16) - filt) + filt,
  // so each update needs only one multiply.
  assign mul_start = (state_r == S_LOAD1) || (state_r == S_LOAD2);
  assign mul_mcand = (state_r == S_LOAD1)
                     ? $signed({d_r[DLT_W-1], d_r, {CNT_W{1'b0}}})
                       - $signed({filt_r[FILT_W-1], filt_r})
                     : $signed({filt_r[FILT_W-1], filt_r});
  assign mul_mult  = (state_r == S_LOAD1) ? {{(MUL_W - GAIN_W){1'b0}}, g} : cfg.scale;

  evf_serial_mult u_mult (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .mcand (mul_mcand),
    .mult  (mul_mult),
    .done  (mul_done),
    .prod  (prod)
  );

  // Round to nearest with ties upward: add half, then shift arithmetically.
  assign t1      = prod + RND_FILT;
  assign fsum    = $signed({rnd_r[RND_W-1], rnd_r})
                   + $signed({{(FSUM_W - FILT_W){filt_r[FILT_W-1]}}, filt_r});
  assign f_max_s = FSUM_W'(FILT_MAX);
  assign f_min_s = -f_max_s;

  always_comb begin
    if (fsum > f_max_s) begin
      f_c = f_max_s[FILT_W-1:0];
    end else if (fsum < f_min_s) begin
      f_c = f_min_s[FILT_W-1:0];
    end else begin
      f_c = fsum[FILT_W-1:0];
    end
  end

  assign t2      = prod + RND_SPEED;
  assign q2      = $signed(t2[PROD_W-1:SPEED_SH]);
  assign s_max_s = SPQ_W'(SPEED_MAX);
  assign s_min_s = SPQ_W'(SPEED_MIN);

  always_comb begin
    if (q2 > s_max_s) begin
      s_c = s_max_s[SPEED_W-1:0];
    end else if (q2 < s_min_s) begin
      s_c = s_min_s[SPEED_W-1:0];
    end else begin
      s_c = q2[SPEED_W-1:0];
    end
  end

  assign spd_x   = $signed({spd_c_r[SPEED_W-1], spd_c_r});
  assign mag     = spd_c_r[SPEED_W-1] ? -spd_x : spd_x;
  assign near    = mag < {{(SPEED_W + 1 - BAND_W){1'b0}}, cfg.band};
  assign run_inc = (run_r == {HOLD_W{1'b1}}) ? run_r : run_r + HOLD_W'(1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.start && !cmd.prime) begin
          state_nxt = S_LOAD1;
        end
      end
      S_LOAD1: state_nxt = S_MUL1;
      S_MUL1: begin
        if (mul_done) begin
          state_nxt = S_FILT;
        end
      end
      S_FILT:  state_nxt = S_LOAD2;
      S_LOAD2: state_nxt = S_MUL2;
      S_MUL2: begin
        if (mul_done) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      prev_r  <= '0;
      filt_r  <= '0;
      vspd_r  <= '0;
      run_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= 1'b0;
      if (state_r == S_IDLE && cmd.start) begin
        prev_r <= count;
        if (cmd.prime) begin
          done_r <= 1'b1;
        end
      end
      if (state_r == S_FILT) begin
        filt_r <= f_c;
      end
      if (state_r == S_HOLD) begin
        done_r <= 1'b1;
        if (near) begin
          run_r <= run_inc;
          if (run_inc >= cfg.hold) begin
            vspd_r <= '0;
          end
        end else begin
          run_r  <= '0;
          vspd_r <= spd_c_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && cmd.start) begin
      d_r <= d_c;
      if (cmd.prime) begin
        res_spd_r <= '0;
      end
    end
    if (state_r == S_MUL1 && mul_done) begin
      rnd_r <= $signed(t1[PROD_W-1:FILT_SH]);
    end
    if (state_r == S_MUL2 && mul_done) begin
      spd_c_r <= s_c;
    end
    if (state_r == S_HOLD) begin
      // A short dip into the zero band shows the last valid speed.
      if (near && run_inc < cfg.hold) begin
        res_spd_r <= vspd_r;
      end else begin
        res_spd_r <= spd_c_r;
      end
    end
  end

  assign done  = done_r;
  assign speed = res_spd_r;
  assign filt  = filt_r;

endmodule
`default_nettype wire

// ===== rtl/encoder_velocity_filter_unit.sv =====
// Each item runs through two six-step passes of each wheel's 4-bit-digit serial
// multiplier, one for the filter and one for the speed; the first item after
// reset only records the counts and gives a zero result. A new item is taken
// only after the last result has been loaded into the output register.
// Reset (rst_n low, synchronous): registers return to their defaults, the
// filter and hold state clear, and the next item primes the counters.
`default_nettype none
module encoder_velocity_filter_unit
  import evf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [CNT_W-1:0]          in_count_left,
  input  logic [CNT_W-1:0]          in_count_right,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [SPEED_W-1:0] out_speed_left,
  output logic signed [SPEED_W-1:0] out_speed_right,
  output logic signed [FILT_W-1:0]  out_filtered_left,
  output logic signed [FILT_W-1:0]  out_filtered_right,
  input  logic                      cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata
);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_RUN  = 2'd1;
  localparam logic [1:0] T_WAIT = 2'd2;

  logic [1:0]                state_r;
  logic [1:0]                state_nxt;
  logic                      primed_r;
  cfg_t                      cfg_r;
  logic                      inv_left_r;
  logic                      inv_right_r;
  logic                      out_valid_r;
  logic signed [SPEED_W-1:0] out_speed_left_r;
  logic signed [SPEED_W-1:0] out_speed_right_r;
  logic signed [FILT_W-1:0]  out_filt_left_r;
  logic signed [FILT_W-1:0]  out_filt_right_r;

  logic                      accept;
  logic                      out_free;
  logic                      load;
  wheel_cmd_t                cmd;
  logic                      wl_done;
  logic                      wr_done;
  logic signed [SPEED_W-1:0] wl_speed;
  logic signed [SPEED_W-1:0] wr_speed;
  logic signed [FILT_W-1:0]  wl_filt;
  logic signed [FILT_W-1:0]  wr_filt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain  <= RST_GAIN;
      cfg_r.limit <= RST_LIMIT;
      cfg_r.scale <= RST_SCALE;
      cfg_r.band  <= RST_BAND;
      cfg_r.hold  <= RST_HOLD;
      inv_left_r  <= 1'b1;
      inv_right_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FILTER_GAIN:      cfg_r.gain  <= cfg_wdata[GAIN_W-1:0];
        REG_DELTA_LIMIT:      cfg_r.limit <= cfg_wdata[LIM_W-1:0];
        REG_SPEED_SCALE:      cfg_r.scale <= cfg_wdata[SCALE_W-1:0];
        REG_ZERO_BAND:        cfg_r.band  <= cfg_wdata[BAND_W-1:0];
        REG_ZERO_HOLD_FRAMES: cfg_r.hold  <= cfg_wdata[HOLD_W-1:0];
        REG_INVERT_LEFT:      inv_left_r  <= cfg_wdata[0];
        REG_INVERT_RIGHT:     inv_right_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_stall  = (state_r != T_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cmd.start = accept;
  assign cmd.prime = !primed_r;

  // The output register frees up in the same cycle that its item is taken.
  assign out_free = !out_valid_r || !out_stall;
  assign load     = ((state_r == T_RUN && wl_done) || state_r == T_WAIT) && out_free;

  evf_wheel u_wheel_left (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .count (in_count_left),
    .inv   (inv_left_r),
    .cfg   (cfg_r),
    .done  (wl_done),
    .speed (wl_speed),
    .filt  (wl_filt)
  );

  evf_wheel u_wheel_right (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .count (in_count_right),
    .inv   (inv_right_r),
    .cfg   (cfg_r),
    .done  (wr_done),
    .speed (wr_speed),
    .filt  (wr_filt)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      T_IDLE: begin
        if (accept) begin
          state_nxt = T_RUN;
        end
      end
      T_RUN: begin
        if (wl_done) begin
          state_nxt = out_free ? T_IDLE : T_WAIT;
        end
      end
      T_WAIT: begin
        if (out_free) begin
          state_nxt = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        primed_r <= 1'b1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_speed_left_r  <= wl_speed;
      out_speed_right_r <= wr_speed;
      out_filt_left_r   <= wl_filt;
      out_filt_right_r  <= wr_filt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_speed_left     = out_speed_left_r;
  assign out_speed_right    = out_speed_right_r;
  assign out_filtered_left  = out_filt_left_r;
  assign out_filtered_right = out_filt_right_r;

  // Both wheel lanes run in lockstep.
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    wl_done == wr_done)
    else $error("wheel lanes finished in different cycles");

  a_done_while_run: assert property (@(posedge clk) disable iff (!rst_n)
    wl_done |-> state_r == T_RUN)
    else $error("wheel finished while no item was in flight");

  a_new_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == T_WAIT || (state_r == T_RUN && wl_done)))
    else $error("result appeared without a finished item");

  a_filt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_filt_left_r <= FILT_MAX && out_filt_left_r >= -FILT_MAX &&
                     out_filt_right_r <= FILT_MAX && out_filt_right_r >= -FILT_MAX))
    else $error("filter output outside its saturation range");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb
  import evf_pkg::*;
;

  typedef struct {
    logic signed [SPEED_W-1:0] speed_left;
    logic signed [SPEED_W-1:0] speed_right;
    logic signed [FILT_W-1:0]  filtered_left;
    logic signed [FILT_W-1:0]  filtered_right;
  } wheel_speeds_t;

  // Scoreboard: keeps its own copy of the registers and wheel state, works out
  // the speeds each accepted item should produce and checks the results in order.
  class wheel_speed_board;
    cfg_t             cfg;
    bit               invert_l;
    bit               invert_r;
    logic [CNT_W-1:0] last_count [2];
    longint           filt_q16 [2];
    longint           held_speed [2];
    int               zero_run [2];
    bit               primed;
    wheel_speeds_t    expected_speeds [$];
    int               mismatches;
    int               results_seen;

    function new();
      cfg.gain  = RST_GAIN;
      cfg.limit = RST_LIMIT;
      cfg.scale = RST_SCALE;
      cfg.band  = RST_BAND;
      cfg.hold  = RST_HOLD;
      invert_l  = 1'b1;
      invert_r  = 1'b0;
      for (int w = 0; w < 2; w++) begin
        last_count[w] = '0;
        filt_q16[w]   = 0;
        held_speed[w] = 0;
        zero_run[w]   = 0;
      end
      primed       = 1'b0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FILTER_GAIN:      cfg.gain  = data[GAIN_W-1:0];
        REG_DELTA_LIMIT:      cfg.limit = data[LIM_W-1:0];
        REG_SPEED_SCALE:      cfg.scale = data[SCALE_W-1:0];
        REG_ZERO_BAND:        cfg.band  = data[BAND_W-1:0];
        REG_ZERO_HOLD_FRAMES: cfg.hold  = data[HOLD_W-1:0];
        REG_INVERT_LEFT:      invert_l  = data[0];
        REG_INVERT_RIGHT:     invert_r  = data[0];
        default: ;
      endcase
    endfunction

    // Divide by 2^sh, rounding to nearest with ties going up.
    function longint round_half_up(longint v, int sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function longint predict_wheel(int w, logic [CNT_W-1:0] count, bit invert);
      logic signed [CNT_W-1:0] diff;
      longint d;
      longint lim;
      longint g;
      longint spd;
      longint mag;
      diff = count - last_count[w];
      d = diff;
      last_count[w] = count;
      if (invert) d = -d;
      lim = longint'(cfg.limit);
      if (d > lim) d = lim;
      else if (d < -lim) d = -lim;
      g = (cfg.gain > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(cfg.gain);
      filt_q16[w] = round_half_up(g * (d <<< 16) + (longint'(GAIN_ONE) - g) * filt_q16[w],
                                  FILT_SH);
      if (filt_q16[w] > FILT_MAX) filt_q16[w] = FILT_MAX;
      else if (filt_q16[w] < -FILT_MAX) filt_q16[w] = -FILT_MAX;
      spd = round_half_up(filt_q16[w] * longint'(cfg.scale), SPEED_SH);
      if (spd > SPEED_MAX) spd = SPEED_MAX;
      else if (spd < SPEED_MIN) spd = SPEED_MIN;
      mag = (spd < 0) ? -spd : spd;
      if (mag < longint'(cfg.band)) begin
        if (zero_run[w] < 255) zero_run[w]++;
        if (zero_run[w] < int'(cfg.hold)) spd = held_speed[w];
        else held_speed[w] = 0;
      end else begin
        zero_run[w]   = 0;
        held_speed[w] = spd;
      end
      return spd;
    endfunction

    function void note_counts(logic [CNT_W-1:0] cl, logic [CNT_W-1:0] cr);
      wheel_speeds_t e;
      if (!primed) begin
        // The first item after reset only records where the counters stand.
        last_count[0] = cl;
        last_count[1] = cr;
        primed = 1'b1;
        e.speed_left     = '0;
        e.speed_right    = '0;
        e.filtered_left  = '0;
        e.filtered_right = '0;
      end else begin
        e.speed_left     = SPEED_W'(predict_wheel(0, cl, invert_l));
        e.speed_right    = SPEED_W'(predict_wheel(1, cr, invert_r));
        e.filtered_left  = FILT_W'(filt_q16[0]);
        e.filtered_right = FILT_W'(filt_q16[1]);
      end
      expected_speeds.push_back(e);
    endfunction

    function int pending();
      return expected_speeds.size();
    endfunction

    task report(string what, longint got, longint want);
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
    endtask

    task check_result(wheel_speeds_t got);
      wheel_speeds_t want;
      results_seen++;
      if (expected_speeds.size() == 0) begin
        report("result with no item pending, speed_left", got.speed_left, 0);
      end else begin
        want = expected_speeds.pop_front();
        if (got.speed_left !== want.speed_left)
          report("speed_left", got.speed_left, want.speed_left);
        if (got.speed_right !== want.speed_right)
          report("speed_right", got.speed_right, want.speed_right);
        if (got.filtered_left !== want.filtered_left)
          report("filtered_left", got.filtered_left, want.filtered_left);
        if (got.filtered_right !== want.filtered_right)
          report("filtered_right", got.filtered_right, want.filtered_right);
      end
    endtask
  endclass

  localparam int QUIET_LIMIT = 2000;
  localparam int BLOCK_LATENCY = 25;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [CNT_W-1:0]          in_count_left = '0;
  logic [CNT_W-1:0]          in_count_right = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [SPEED_W-1:0] out_speed_left;
  logic signed [SPEED_W-1:0] out_speed_right;
  logic signed [FILT_W-1:0]  out_filtered_left;
  logic signed [FILT_W-1:0]  out_filtered_right;
  logic                      cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_wdata = '0;

  wheel_speed_board board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int settings_used = 1;
  int quiet_cycles = 0;
  logic [CNT_W-1:0] last_l = '0;
  logic [CNT_W-1:0] last_r = '0;

  encoder_velocity_filter_unit DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    wheel_speeds_t got;
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      got.speed_left     = out_speed_left;
      got.speed_right    = out_speed_right;
      got.filtered_left  = out_filtered_left;
      got.filtered_right = out_filtered_right;
      board.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Leaves in_valid high after acceptance so back-to-back items need no toggle.
  task automatic send_counts(input logic [CNT_W-1:0] cl, input logic [CNT_W-1:0] cr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_count_left  <= cl;
    in_count_right <= cr;
    do @(posedge clk); while (in_stall);
    board.note_counts(cl, cr);
    last_l = cl;
    last_r = cr;
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    board.write_reg(idx, data);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly small moves and standstill so the filter settles and the hold logic
  // is reached; now and then a jump anywhere on the counter.
  function automatic logic [CNT_W-1:0] next_count(logic [CNT_W-1:0] prev, int lim);
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) return prev;
    if (pick < 65) return prev + CNT_W'($urandom_range(8)) - CNT_W'(4);
    if (pick < 90) return prev + CNT_W'($urandom_range(2 * lim + 8)) - CNT_W'(lim + 4);
    return CNT_W'($urandom);
  endfunction

  task automatic random_settings();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(4))
      0: v = CFG_DATA_W'(0);
      1: v = CFG_DATA_W'(32768);
      2: v = CFG_DATA_W'($urandom_range(65535, 32769));
      3: v = CFG_DATA_W'(RST_GAIN);
      default: v = CFG_DATA_W'($urandom_range(32768));
    endcase
    write_reg(REG_FILTER_GAIN, v);
    case ($urandom_range(4))
      0: v = CFG_DATA_W'(0);
      1: v = CFG_DATA_W'(1);
      2: v = CFG_DATA_W'(32767);
      3: v = CFG_DATA_W'(RST_LIMIT);
      default: v = CFG_DATA_W'($urandom_range(2000, 1));
    endcase
    write_reg(REG_DELTA_LIMIT, v);
    case ($urandom_range(4))
      0: v = CFG_DATA_W'(0);
      1: v = 24'hFFFFFF;
      2: v = CFG_DATA_W'(RST_SCALE);
      3: v = CFG_DATA_W'($urandom_range(24'hFFFFFF));
      default: v = CFG_DATA_W'($urandom_range(200000, 1000));
    endcase
    write_reg(REG_SPEED_SCALE, v);
    case ($urandom_range(3))
      0: v = CFG_DATA_W'(0);
      1: v = CFG_DATA_W'(65535);
      2: v = CFG_DATA_W'(RST_BAND);
      default: v = CFG_DATA_W'($urandom_range(3000));
    endcase
    write_reg(REG_ZERO_BAND, v);
    case ($urandom_range(4))
      0: v = CFG_DATA_W'(0);
      1: v = CFG_DATA_W'(1);
      2: v = CFG_DATA_W'(255);
      3: v = CFG_DATA_W'(RST_HOLD);
      default: v = CFG_DATA_W'($urandom_range(20, 1));
    endcase
    write_reg(REG_ZERO_HOLD_FRAMES, v);
    write_reg(REG_INVERT_LEFT, CFG_DATA_W'($urandom_range(1)));
    write_reg(REG_INVERT_RIGHT, CFG_DATA_W'($urandom_range(1)));
    if ($urandom_range(3) == 0) write_reg(CFG_IDX_W'(7), CFG_DATA_W'($urandom));
    settings_used++;
  endtask

  initial begin
    int coast;
    logic [CNT_W-1:0] cl;
    logic [CNT_W-1:0] cr;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: priming item, counter wrap on the right, then a step.
    send_counts(16'h1234, 16'hFFFF);
    send_counts(16'h1235, 16'h0000);
    send_counts(16'h1335, 16'h0100);
    repeat (3) send_counts(16'h1335, 16'h0100);

    // Full gain, widest limit and scale: both saturation corners, half-range jumps.
    drain();
    write_reg(REG_FILTER_GAIN, 24'd32768);
    write_reg(REG_DELTA_LIMIT, 24'd32767);
    write_reg(REG_SPEED_SCALE, 24'hFFFFFF);
    write_reg(REG_ZERO_BAND, 24'd0);
    write_reg(REG_ZERO_HOLD_FRAMES, 24'd0);
    write_reg(REG_INVERT_LEFT, 24'd0);
    write_reg(REG_INVERT_RIGHT, 24'd1);
    write_reg(CFG_IDX_W'(7), 24'hFFFFFF);
    settings_used++;
    send_counts(16'h0000, 16'h0000);
    send_counts(16'h7FFF, 16'h7FFF);
    send_counts(16'hFFFF, 16'hFFFF);
    send_counts(16'h7FFF, 16'h8000);
    send_counts(16'h7FFF, 16'h8000);

    // Gain above one, a zero limit, the widest band and the longest hold.
    drain();
    write_reg(REG_FILTER_GAIN, 24'd65535);
    write_reg(REG_DELTA_LIMIT, 24'd0);
    write_reg(REG_ZERO_BAND, 24'd65535);
    write_reg(REG_ZERO_HOLD_FRAMES, 24'd255);
    settings_used++;
    send_counts(16'h1234, 16'hABCD);
    send_counts(16'h0000, 16'hFFFF);
    send_counts(16'h8000, 16'h0000);
    send_counts(16'hFFFF, 16'h8000);

    // Zero gain freezes the filter; smallest nonzero limit, scale, band and hold.
    drain();
    write_reg(REG_FILTER_GAIN, 24'd0);
    write_reg(REG_DELTA_LIMIT, 24'd1);
    write_reg(REG_SPEED_SCALE, 24'd1);
    write_reg(REG_ZERO_BAND, 24'd1);
    write_reg(REG_ZERO_HOLD_FRAMES, 24'd1);
    write_reg(REG_INVERT_LEFT, 24'd1);
    settings_used++;
    send_counts(16'h0001, 16'hFFFE);
    send_counts(16'h0002, 16'hFFFD);
    send_counts(16'h0000, 16'h0000);

    for (int mode = 0; mode < 3; mode++) begin
      for (int sub = 0; sub < 5; sub++) begin
        drain();
        send_idle_pct  = (mode == 0) ? 7 : (mode == 1) ? 83 : 0;
        recv_stall_pct = (mode == 0) ? 83 : (mode == 1) ? 7 : 0;
        random_settings();
        coast = 0;
        for (int n = 0; n < 60; n++) begin
          // Standstill stretches let the speed decay into the zero band.
          if (coast > 0) begin
            coast--;
            cl = last_l;
            cr = last_r;
          end else begin
            if ($urandom_range(9) == 0) coast = $urandom_range(20, 4);
            cl = next_count(last_l, int'(board.cfg.limit));
            cr = next_count(last_r, int'(board.cfg.limit));
          end
          send_counts(cl, cr);
        end
      end
    end

    drain();
    repeat (BLOCK_LATENCY) @(posedge clk);
    $display("Ran %0d items and checked %0d results over %0d register settings,",
             items_sent, board.results_seen, settings_used);
    $display("with sender and receiver idling in turn and then running flat out.");
    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
